/* hdl/i2ctr_pkg.sv */
`default_nettype none

package i2ctr_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_ACKS      = 1'd1;

    localparam logic [7:0] ADDR_MASK = 8'hFE;
    localparam logic [7:0] RW_BIT    = 8'h01;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDRESS,
        PH_WRITE,
        PH_READ,
        PH_IGNORE
    } t_phase;

    typedef struct packed {
        logic [7:0] target_address_byte;
        logic       send_acks;
    } t_cfg;

    typedef struct packed {
        logic       sda_pull_low;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       start_seen;
        logic       stop_seen;
        logic       read_requested;
    } t_result;

endpackage

`default_nettype wire

/* hdl/i2ctr_ifs.sv */
`default_nettype none

interface i2ctr_sample_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;

    modport source (output valid, output scl_level, output sda_level, input ready);
    modport sink   (input valid, input scl_level, input sda_level, output ready);
endinterface

interface i2ctr_result_if;
    logic       valid;
    logic       ready;
    logic       sda_pull_low;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       start_seen;
    logic       stop_seen;
    logic       read_requested;

    modport source (
        output valid, output sda_pull_low, output byte_valid, output byte_value,
        output start_seen, output stop_seen, output read_requested, input ready
    );
    modport sink (
        input valid, input sda_pull_low, input byte_valid, input byte_value,
        input start_seen, input stop_seen, input read_requested, output ready
    );
endinterface

`default_nettype wire

/* hdl/i2ctr_cfg_regs.sv */
`default_nettype none

module i2ctr_cfg_regs
    import i2ctr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [CFG_IDX_W-1:0]  i_idx,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            case (i_idx)
                CFG_TARGET_ADDRESS: begin
                    r_cfg.target_address_byte <= i_data[7:0];
                end
                CFG_SEND_ACKS: begin
                    r_cfg.send_acks <= i_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hdl/i2ctr_step.sv */
`default_nettype none

module i2ctr_step
    import i2ctr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire logic i_scl,
    input  wire logic i_sda,
    input  t_cfg      i_cfg,
    output t_result   o_res
);

    logic       r_last_scl, n_last_scl;
    logic       r_last_sda, n_last_sda;
    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_shift, n_shift;
    logic       r_ack, n_ack;

    logic       bus_cond;
    logic       scl_rise;
    logic       scl_fall;
    logic       addr_match;
    logic [7:0] want;
    logic [7:0] shifted;

    assign bus_cond = r_last_scl && i_scl && (r_last_sda != i_sda);
    assign scl_rise = !r_last_scl && i_scl;
    assign scl_fall = r_last_scl && !i_scl;
    assign want       = i_cfg.target_address_byte & ADDR_MASK;
    assign addr_match = (want != 8'd0) && ((r_shift & ADDR_MASK) == want);
    assign shifted    = {r_shift[6:0], i_sda};

    // next state
    always_comb begin
        n_last_scl = i_scl;
        n_last_sda = i_sda;
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_ack      = r_ack;
        if (bus_cond) begin
            n_ack     = 1'b0;
            n_bit_cnt = 4'd0;
            n_shift   = 8'd0;
            n_phase   = i_sda ? PH_IDLE : PH_ADDRESS;
        end else if (scl_rise) begin
            if (r_phase == PH_ADDRESS || r_phase == PH_WRITE) begin
                if (r_bit_cnt < BITS_PER_BYTE) begin
                    n_shift   = shifted;
                    n_bit_cnt = r_bit_cnt + 4'd1;
                end else begin
                    // acknowledge clock, after all data bits are shifted in
                    n_bit_cnt = 4'd0;
                    n_shift   = 8'd0;
                    if (r_phase == PH_ADDRESS) begin
                        if (!addr_match) begin
                            n_phase = PH_IGNORE;
                        end else if ((r_shift & RW_BIT) != 8'd0) begin
                            n_phase = PH_READ;
                        end else begin
                            n_phase = PH_WRITE;
                        end
                    end
                end
            end
        end else if (scl_fall) begin
            n_ack = (r_bit_cnt == BITS_PER_BYTE) && i_cfg.send_acks &&
                    (r_phase == PH_WRITE || (r_phase == PH_ADDRESS && addr_match));
        end
    end

    // result of this sample
    always_comb begin
        o_res              = '0;
        o_res.sda_pull_low = n_ack;
        o_res.start_seen   = bus_cond && !i_sda;
        o_res.stop_seen    = bus_cond && i_sda;
        if (!bus_cond && scl_rise) begin
            if (r_phase == PH_WRITE && r_bit_cnt == BITS_PER_BYTE - 4'd1) begin
                o_res.byte_valid = 1'b1;
                o_res.byte_value = shifted;
            end
            if (r_phase == PH_ADDRESS && r_bit_cnt == BITS_PER_BYTE && addr_match &&
                (r_shift & RW_BIT) != 8'd0) begin
                o_res.read_requested = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_scl <= 1'b1;
            r_last_sda <= 1'b1;
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= 4'd0;
            r_shift    <= 8'd0;
            r_ack      <= 1'b0;
        end else if (i_fire) begin
            r_last_scl <= n_last_scl;
            r_last_sda <= n_last_sda;
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_ack      <= n_ack;
        end
    end

endmodule

`default_nettype wire

/* hdl/i2c_target_receiver_unit.sv */
// path: sample register, bus step, result register; a sample moves on only while the output is free
// throughput: one sample per cycle while the output is not stalled; bus state updates with each moved sample
// sample and result registers hold one sample each; under back-pressure the input stalls once both are full
// reset: synchronous active low; bus lines taken as idle high, phase idle, config zero
`default_nettype none

module i2c_target_receiver_unit
    import i2ctr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    i2ctr_sample_if.sink               i_in,
    i2ctr_result_if.source             o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result step_res;

    // sample register
    logic r_in_valid;
    logic r_scl;
    logic r_sda;

    // result register
    logic    r_out_valid;
    t_result r_res;

    // the result stage moves when it is empty or its transfer completes
    logic advance;
    logic step_fire;

    assign advance   = !r_out_valid || o_out.ready;
    assign step_fire = advance && r_in_valid;
    assign i_in.ready = advance || !r_in_valid;

    i2ctr_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    // bus state lives here and updates only when a sample moves to the result stage
    i2ctr_step u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (step_fire),
        .i_scl  (r_scl),
        .i_sda  (r_sda),
        .i_cfg  (cfg),
        .o_res  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_scl <= i_in.scl_level;
            r_sda <= i_in.sda_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sda_pull_low   = r_res.sda_pull_low;
    assign o_out.byte_valid     = r_res.byte_valid;
    assign o_out.byte_value     = r_res.byte_value;
    assign o_out.start_seen     = r_res.start_seen;
    assign o_out.stop_seen      = r_res.stop_seen;
    assign o_out.read_requested = r_res.read_requested;

endmodule

`default_nettype wire

/* hdl/i2ctr_checker.sv */
`default_nettype none

module i2ctr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_pull_low,
    input wire logic       i_byte_valid,
    input wire logic [7:0] i_byte_value,
    input wire logic       i_start,
    input wire logic       i_stop,
    input wire logic       i_read_req
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable({i_pull_low, i_byte_valid, i_byte_value, i_start, i_stop, i_read_req})))
        else $error("stalled result changed");

    a_cond_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_start && i_stop))
        else $error("start and stop in one sample");

    // a data byte lands on a rising clock, never with a bus condition or an ack
    a_byte_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_byte_valid) |-> (!i_pull_low && !i_start && !i_stop && !i_read_req))
        else $error("byte completed alongside another event");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_byte_valid) |-> (i_byte_value == 8'd0))
        else $error("byte value without byte valid");

endmodule

bind i2c_target_receiver_unit i2ctr_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pull_low  (o_out.sda_pull_low),
    .i_byte_valid(o_out.byte_valid),
    .i_byte_value(o_out.byte_value),
    .i_start     (o_out.start_seen),
    .i_stop      (o_out.stop_seen),
    .i_read_req  (o_out.read_requested)
);

`default_nettype wire
